// ===== rtl/core/btbr_pkg.sv =====
// ----------------------------------------------------------------------------
// btbr_pkg
// Shared sizes, codes and types of the branch target buffer with return
// address stack.
// ----------------------------------------------------------------------------
package btbr_pkg;

   // table sizes (sets, call size and indirect entries are powers of two)
   localparam int NUM_SETS    = 1024;
   localparam int NUM_WAYS    = 8;
   localparam int IND_ENTRIES = 4096;
   localparam int RAS_DEPTH   = 64;
   localparam int CSZ_ENTRIES = 1024;

   localparam int BTB_DEPTH = NUM_SETS * NUM_WAYS;
   localparam int SET_BITS  = $clog2(NUM_SETS);
   localparam int WAY_BITS  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int BTB_AW    = $clog2(BTB_DEPTH);
   localparam int IND_AW    = $clog2(IND_ENTRIES);
   localparam int RAS_AW    = (RAS_DEPTH > 1) ? $clog2(RAS_DEPTH) : 1;
   localparam int CSZ_AW    = $clog2(CSZ_ENTRIES);

   // the clearing sweep covers the deepest store
   localparam int CLR_DEPTH_A = (BTB_DEPTH > IND_ENTRIES) ? BTB_DEPTH : IND_ENTRIES;
   localparam int CLR_DEPTH_B = (RAS_DEPTH > CSZ_ENTRIES) ? RAS_DEPTH : CSZ_ENTRIES;
   localparam int CLR_DEPTH   = (CLR_DEPTH_A > CLR_DEPTH_B) ? CLR_DEPTH_A : CLR_DEPTH_B;
   localparam int CLR_W       = $clog2(CLR_DEPTH + 1);

   localparam int HIST_W          = 12;
   localparam int CSZ_W           = 4;
   localparam int MAX_LEARNED     = 10;
   localparam int INIT_CALL_SIZE  = 4;

   typedef enum logic [2:0] {
      KIND_NONE     = 3'd0,
      KIND_JUMP     = 3'd1,
      KIND_INDIRECT = 3'd2,
      KIND_COND     = 3'd3,
      KIND_DCALL    = 3'd4,
      KIND_ICALL    = 3'd5,
      KIND_RETURN   = 3'd6,
      KIND_OTHER    = 3'd7
   } kind_type;

   typedef enum logic {
      REQ_PREDICT = 1'b0,
      REQ_UPDATE  = 1'b1
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_RAS_DATA,
      ST_CSZ_DATA,
      ST_IND_DATA,
      ST_SCAN,
      ST_SCAN_END,
      ST_BTB_FIN
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] tag;
      logic [63:0] target;
      logic        sticky_taken;
      logic [63:0] stamp;
   } btb_entry_type;

   typedef struct packed {
      logic                hit;
      logic [WAY_BITS-1:0] hit_way;
      btb_entry_type       hit_entry;
      logic [WAY_BITS-1:0] best_way;
   } scan_res_type;

endpackage

// ===== rtl/core/btbr_ram.sv =====
// ----------------------------------------------------------------------------
// btbr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module btbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/btbr_scan.sv =====
// ----------------------------------------------------------------------------
// btbr_scan
// Way scan unit: takes one BTB way per cycle, tracks the tag hit and the
// way with the lowest use stamp.
// ----------------------------------------------------------------------------
module btbr_scan
   import btbr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                scan_clear,
   input  logic                scan_en,
   input  logic [WAY_BITS-1:0] scan_way,
   input  logic [63:0]         scan_ip,
   input  btb_entry_type       scan_entry,
   output scan_res_type        scan_res
);

   logic                hit_ff;
   logic [WAY_BITS-1:0] hit_way_ff;
   btb_entry_type       hit_entry_ff;
   logic [WAY_BITS-1:0] best_way_ff;
   logic [63:0]         best_stamp_ff;
   logic                match;
   logic                better;

   // shared tag and stamp compare
   assign match  = scan_entry.valid && (scan_entry.tag == scan_ip) && !hit_ff;
   assign better = (scan_way == '0) || (scan_entry.stamp < best_stamp_ff);

   // hit tracking
   always_ff @(posedge clock) begin
      if (reset || scan_clear) begin
         hit_ff <= 1'b0;
      end else if (scan_en && match) begin
         hit_ff <= 1'b1;
      end
   end

   // hit payload and victim tracking
   always_ff @(posedge clock) begin
      if (scan_en) begin
         if (match) begin
            hit_way_ff   <= scan_way;
            hit_entry_ff <= scan_entry;
         end
         if (better) begin
            best_way_ff   <= scan_way;
            best_stamp_ff <= scan_entry.stamp;
         end
      end
   end

   assign scan_res.hit       = hit_ff;
   assign scan_res.hit_way   = hit_way_ff;
   assign scan_res.hit_entry = hit_entry_ff;
   assign scan_res.best_way  = best_way_ff;

endmodule

// ===== rtl/core/branch_target_buffer_with_ras_core.sv =====
// ----------------------------------------------------------------------------
// branch_target_buffer_with_ras_core
// Branch target predictor: set-associative BTB, indirect target table,
// return address stack and call size table under one sequencer.
// ----------------------------------------------------------------------------
// Usage
//  - req_* beats carry a predict (req_type 0) or an update (req_type 1);
//    a beat is taken when req_valid is high and req_stall is low.
//  - a predict gives one rsp_* beat (target and always-taken flag);
//    an update gives none.
//  - one item at a time; req_stall is high while an item is in flight.
//  - BTB kinds read one way per cycle through the shared tag/stamp
//    compare unit; a return predict reads the stack top and then the
//    call size table, a return update reads it and pops; an indirect
//    predict reads the indirect table, an indirect update writes it.
//  - results sit in an output register; the next item is taken while a
//    result waits, and the sequencer holds a predict's final step while the
//    output register is full and rsp_stall is high.
//  - after reset a clearing pass over CLR_DEPTH addresses (8192 with the
//    default sizes) writes every store to its reset value; req_stall is
//    high until it ends.
// ----------------------------------------------------------------------------
module branch_target_buffer_with_ras_core
   import btbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [63:0] req_branch_ip,
   input  logic [2:0]  req_branch_kind,
   input  logic [63:0] req_actual_target,
   input  logic        req_was_taken,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_predicted_target,
   output logic        rsp_predicted_always_taken
);

   state_type           state_ff, state_in;
   logic [CLR_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [WAY_BITS-1:0] way_cnt_ff, way_cnt_in;
   logic                rd_pend_ff;
   logic [WAY_BITS-1:0] rd_way_ff;
   logic [63:0]         stamp_ff, stamp_in;
   logic [HIST_W-1:0]   hist_ff, hist_in;
   logic [RAS_AW-1:0]   top_ff, top_in;
   logic [63:0]         ret_ip_ff, ret_ip_in;

   // latched item
   req_kind_type        type_ff;
   logic [63:0]         ip_ff;
   kind_type            kind_ff;
   logic [63:0]         tgt_ff;
   logic                taken_ff;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         rsp_target_ff;
   logic                rsp_at_ff;
   logic                rsp_load;
   logic [63:0]         rsp_target_in;
   logic                rsp_at_in;
   logic                out_free;

   // memory ports
   logic                btb_wr_en, btb_rd_en;
   logic [BTB_AW-1:0]   btb_wr_addr, btb_rd_addr;
   btb_entry_type       btb_wr_data, btb_rd_data;
   logic                ind_wr_en, ind_rd_en;
   logic [IND_AW-1:0]   ind_wr_addr, ind_rd_addr;
   logic [63:0]         ind_wr_data, ind_rd_data;
   logic                ras_wr_en, ras_rd_en;
   logic [RAS_AW-1:0]   ras_wr_addr, ras_rd_addr;
   logic [63:0]         ras_wr_data, ras_rd_data;
   logic                csz_wr_en, csz_rd_en;
   logic [CSZ_AW-1:0]   csz_wr_addr, csz_rd_addr;
   logic [CSZ_W-1:0]    csz_wr_data, csz_rd_data;

   // scan unit
   logic                scan_clear;
   scan_res_type        scan_res;

   // derived values
   logic                is_ind;
   logic                is_call;
   logic [RAS_AW-1:0]   top_inc, top_dec;
   logic [63:0]         ind_mix;
   logic [IND_AW-1:0]   ind_idx;
   logic [BTB_AW-1:0]   set_base;
   logic [63:0]         ret_dist;
   logic                dist_ok;

   assign is_ind  = (kind_ff == KIND_INDIRECT) || (kind_ff == KIND_ICALL);
   assign is_call = (kind_ff == KIND_DCALL) || (kind_ff == KIND_ICALL);
   assign top_inc = (top_ff == RAS_AW'(RAS_DEPTH - 1)) ? '0 : top_ff + 1'b1;
   assign top_dec = (top_ff == '0) ? RAS_AW'(RAS_DEPTH - 1) : top_ff - 1'b1;
   assign ind_mix = (ip_ff >> 2) ^ {{(64 - HIST_W){1'b0}}, hist_ff};
   assign ind_idx = ind_mix[IND_AW-1:0];
   assign set_base = BTB_AW'(ip_ff[2 +: SET_BITS]) * BTB_AW'(NUM_WAYS);
   assign ret_dist = (ras_rd_data > tgt_ff) ? ras_rd_data - tgt_ff : tgt_ff - ras_rd_data;
   assign dist_ok  = ret_dist <= 64'(MAX_LEARNED);
   assign out_free = !(rsp_valid_ff && rsp_stall);

   // stores
   btbr_ram #(.WIDTH($bits(btb_entry_type)), .DEPTH(BTB_DEPTH)) u_btb_ram (
      .clock   (clock),
      .wr_en   (btb_wr_en),
      .wr_addr (btb_wr_addr),
      .wr_data (btb_wr_data),
      .rd_en   (btb_rd_en),
      .rd_addr (btb_rd_addr),
      .rd_data (btb_rd_data)
   );

   btbr_ram #(.WIDTH(64), .DEPTH(IND_ENTRIES)) u_ind_ram (
      .clock   (clock),
      .wr_en   (ind_wr_en),
      .wr_addr (ind_wr_addr),
      .wr_data (ind_wr_data),
      .rd_en   (ind_rd_en),
      .rd_addr (ind_rd_addr),
      .rd_data (ind_rd_data)
   );

   btbr_ram #(.WIDTH(64), .DEPTH(RAS_DEPTH)) u_ras_ram (
      .clock   (clock),
      .wr_en   (ras_wr_en),
      .wr_addr (ras_wr_addr),
      .wr_data (ras_wr_data),
      .rd_en   (ras_rd_en),
      .rd_addr (ras_rd_addr),
      .rd_data (ras_rd_data)
   );

   btbr_ram #(.WIDTH(CSZ_W), .DEPTH(CSZ_ENTRIES)) u_csz_ram (
      .clock   (clock),
      .wr_en   (csz_wr_en),
      .wr_addr (csz_wr_addr),
      .wr_data (csz_wr_data),
      .rd_en   (csz_rd_en),
      .rd_addr (csz_rd_addr),
      .rd_data (csz_rd_data)
   );

   // way scan unit
   btbr_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .scan_clear (scan_clear),
      .scan_en    (rd_pend_ff),
      .scan_way   (rd_way_ff),
      .scan_ip    (ip_ff),
      .scan_entry (btb_rd_data),
      .scan_res   (scan_res)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         way_cnt_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         stamp_ff     <= '0;
         hist_ff      <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         way_cnt_ff   <= way_cnt_in;
         rd_pend_ff   <= (state_ff == ST_SCAN);
         stamp_ff     <= stamp_in;
         hist_ff      <= hist_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_way_ff <= way_cnt_ff;
      ret_ip_ff <= ret_ip_in;
      if (state_ff == ST_IDLE && req_valid) begin
         type_ff  <= req_kind_type'(req_type);
         ip_ff    <= req_branch_ip;
         kind_ff  <= kind_type'(req_branch_kind);
         tgt_ff   <= req_actual_target;
         taken_ff <= req_was_taken;
      end
      if (rsp_load) begin
         rsp_target_ff <= rsp_target_in;
         rsp_at_ff     <= rsp_at_in;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      way_cnt_in    = way_cnt_ff;
      stamp_in      = stamp_ff;
      hist_in       = hist_ff;
      top_in        = top_ff;
      ret_ip_in     = ret_ip_ff;
      scan_clear    = 1'b0;
      rsp_load      = 1'b0;
      rsp_target_in = '0;
      rsp_at_in     = 1'b1;

      btb_wr_en   = 1'b0;
      btb_wr_addr = set_base + BTB_AW'(scan_res.hit_way);
      btb_wr_data = scan_res.hit_entry;
      btb_rd_en   = 1'b0;
      btb_rd_addr = set_base + BTB_AW'(way_cnt_ff);
      ind_wr_en   = 1'b0;
      ind_wr_addr = ind_idx;
      ind_wr_data = tgt_ff;
      ind_rd_en   = 1'b0;
      ind_rd_addr = ind_idx;
      ras_wr_en   = 1'b0;
      ras_wr_addr = top_ff;
      ras_wr_data = '0;
      ras_rd_en   = 1'b0;
      ras_rd_addr = top_ff;
      csz_wr_en   = 1'b0;
      csz_wr_addr = ras_rd_data[CSZ_AW-1:0];
      csz_wr_data = ret_dist[CSZ_W-1:0];
      csz_rd_en   = 1'b0;
      csz_rd_addr = ras_rd_data[CSZ_AW-1:0];

      case (state_ff)
         // write every store to its reset value
         ST_CLEAR: begin
            btb_wr_en   = clr_cnt_ff < CLR_W'(BTB_DEPTH);
            btb_wr_addr = clr_cnt_ff[BTB_AW-1:0];
            btb_wr_data = '0;
            ind_wr_en   = clr_cnt_ff < CLR_W'(IND_ENTRIES);
            ind_wr_addr = clr_cnt_ff[IND_AW-1:0];
            ind_wr_data = '0;
            ras_wr_en   = clr_cnt_ff < CLR_W'(RAS_DEPTH);
            ras_wr_addr = clr_cnt_ff[RAS_AW-1:0];
            ras_wr_data = '0;
            csz_wr_en   = clr_cnt_ff < CLR_W'(CSZ_ENTRIES);
            csz_wr_addr = clr_cnt_ff[CSZ_AW-1:0];
            csz_wr_data = CSZ_W'(INIT_CALL_SIZE);
            clr_cnt_in  = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_W'(CLR_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end

         // pick the path; call predicts push, updates write indirect and history
         ST_DISPATCH: begin
            if (type_ff == REQ_PREDICT) begin
               if (is_call) begin
                  top_in      = top_inc;
                  ras_wr_en   = 1'b1;
                  ras_wr_addr = top_inc;
                  ras_wr_data = ip_ff;
               end
            end else begin
               if (is_ind) begin
                  ind_wr_en = 1'b1;
               end
               if (kind_ff == KIND_COND) begin
                  hist_in = {hist_ff[HIST_W-2:0], taken_ff};
               end
            end
            if (kind_ff == KIND_RETURN) begin
               ras_rd_en = 1'b1;
               state_in  = ST_RAS_DATA;
            end else if (is_ind) begin
               if (type_ff == REQ_PREDICT) begin
                  ind_rd_en = 1'b1;
                  state_in  = ST_IND_DATA;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               scan_clear = 1'b1;
               way_cnt_in = '0;
               state_in   = ST_SCAN;
            end
         end

         // stack top is here: look up call size or pop and learn
         ST_RAS_DATA: begin
            ret_ip_in = ras_rd_data;
            if (type_ff == REQ_PREDICT) begin
               csz_rd_en = 1'b1;
               state_in  = ST_CSZ_DATA;
            end else begin
               ras_wr_en = 1'b1;
               top_in    = top_dec;
               csz_wr_en = dist_ok;
               state_in  = ST_IDLE;
            end
         end

         ST_CSZ_DATA: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_target_in = ret_ip_ff + {{(64 - CSZ_W){1'b0}}, csz_rd_data};
               state_in      = ST_IDLE;
            end
         end

         ST_IND_DATA: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_target_in = ind_rd_data;
               state_in      = ST_IDLE;
            end
         end

         // read one way per cycle into the scan unit
         ST_SCAN: begin
            btb_rd_en  = 1'b1;
            way_cnt_in = way_cnt_ff + 1'b1;
            if (way_cnt_ff == WAY_BITS'(NUM_WAYS - 1)) begin
               state_in = ST_SCAN_END;
            end
         end

         ST_SCAN_END: begin
            state_in = ST_BTB_FIN;
         end

         // respond, touch, rewrite or allocate
         ST_BTB_FIN: begin
            if (type_ff == REQ_PREDICT) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
                  if (scan_res.hit) begin
                     rsp_target_in     = scan_res.hit_entry.target;
                     rsp_at_in         = scan_res.hit_entry.sticky_taken;
                     btb_wr_en         = 1'b1;
                     btb_wr_data.stamp = stamp_ff;
                     stamp_in          = stamp_ff + 64'd1;
                  end
               end
            end else begin
               state_in = ST_IDLE;
               if (scan_res.hit) begin
                  btb_wr_en                = 1'b1;
                  btb_wr_data.target       = tgt_ff;
                  btb_wr_data.sticky_taken = scan_res.hit_entry.sticky_taken & taken_ff;
               end else if (taken_ff && tgt_ff != '0) begin
                  btb_wr_en                = 1'b1;
                  btb_wr_addr              = set_base + BTB_AW'(scan_res.best_way);
                  btb_wr_data.valid        = 1'b1;
                  btb_wr_data.tag          = ip_ff;
                  btb_wr_data.target       = tgt_ff;
                  btb_wr_data.sticky_taken = 1'b1;
                  btb_wr_data.stamp        = stamp_ff;
                  stamp_in                 = stamp_ff + 64'd1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // output register handshake
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall                  = (state_ff != ST_IDLE);
   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_predicted_target       = rsp_target_ff;
   assign rsp_predicted_always_taken = rsp_at_ff;

endmodule
